[src/sqpg_pkg.sv]
// ---------------------------------------------------------------------------
// sqpg_pkg
// Shared types and constants of the square path reference generator: the
// configuration register map, the register reset values, the phase codes
// and the bundle of configuration values handed to the datapath.
// ---------------------------------------------------------------------------
package sqpg_pkg;

  // Default width of the position outputs (Q16.16 at 32 bits).
  localparam int unsigned PosWidthDef = 32;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Binary angle of one quarter turn (65536 per turn).
  localparam logic [15:0] QuarterTurn = 16'd16384;

  // Configuration register map.
  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_DIR_COS       = 3'd2,
    REG_DIR_SIN       = 3'd3,
    REG_START_HEADING = 3'd4,
    REG_SPEED         = 3'd5,
    REG_SIDE_TICKS    = 3'd6,
    REG_START_TIME    = 3'd7
  } cfg_reg_e;

  // Register reset values.
  localparam logic [31:0] OriginXRst      = 32'd0;
  localparam logic [31:0] OriginYRst      = 32'd0;
  localparam logic [15:0] DirCosRst       = 16'd32767;
  localparam logic [15:0] DirSinRst       = 16'd0;
  localparam logic [15:0] StartHeadingRst = 16'd0;
  localparam logic [30:0] SpeedRst        = 31'd0;
  localparam logic [31:0] SideTicksRst    = 32'd1;
  localparam logic [31:0] StartTimeRst    = 32'd0;

  // Phase codes of a result.
  localparam logic [2:0] PhBefore = 3'd0;
  localparam logic [2:0] PhSide1  = 3'd1;
  localparam logic [2:0] PhSide2  = 3'd2;
  localparam logic [2:0] PhSide3  = 3'd3;
  localparam logic [2:0] PhSide4  = 3'd4;
  localparam logic [2:0] PhDone   = 3'd5;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [15:0] dir_cos;
    logic [15:0] dir_sin;
    logic [15:0] start_heading;
    logic [30:0] speed;
    logic [31:0] side_ticks;
    logic [31:0] start_time;
  } cfg_t;

endpackage

[src/sqpg_cfg_regs.sv]
// ---------------------------------------------------------------------------
// sqpg_cfg_regs
// Configuration register file of the square path reference generator.
// Decodes single-cycle writes and presents all registers as one bundle.
// ---------------------------------------------------------------------------
module sqpg_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sqpg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sqpg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output sqpg_pkg::cfg_t                 cfg_o
);
  import sqpg_pkg::*;

  cfg_t cfg_q;

  // Register writes; bits above a register's width are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x      <= OriginXRst;
      cfg_q.origin_y      <= OriginYRst;
      cfg_q.dir_cos       <= DirCosRst;
      cfg_q.dir_sin       <= DirSinRst;
      cfg_q.start_heading <= StartHeadingRst;
      cfg_q.speed         <= SpeedRst;
      cfg_q.side_ticks    <= SideTicksRst;
      cfg_q.start_time    <= StartTimeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ORIGIN_X:      cfg_q.origin_x      <= cfg_wdata_i;
        REG_ORIGIN_Y:      cfg_q.origin_y      <= cfg_wdata_i;
        REG_DIR_COS:       cfg_q.dir_cos       <= cfg_wdata_i[15:0];
        REG_DIR_SIN:       cfg_q.dir_sin       <= cfg_wdata_i[15:0];
        REG_START_HEADING: cfg_q.start_heading <= cfg_wdata_i[15:0];
        REG_SPEED:         cfg_q.speed         <= cfg_wdata_i[30:0];
        REG_SIDE_TICKS:    cfg_q.side_ticks    <= cfg_wdata_i;
        REG_START_TIME:    cfg_q.start_time    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/square_path_reference_generator_core.sv]
// ---------------------------------------------------------------------------
// square_path_reference_generator_core
// Reference pose and velocity of a robot driving a square at constant speed,
// computed for one time tick per transaction.
// ---------------------------------------------------------------------------
// The block accepts one tick query in every clock cycle while the pipeline is
// not stalled, and presents its results at the outputs in order. It is a
// four-stage pipeline: elapsed time and velocity scaling products, side
// decode by comparison against one to four side lengths, the position
// products, and the final sum with saturation, which sits in the output
// register. The output register and every stage stall in place when the
// result is not taken, and a stage takes a new transaction whenever it is
// empty or moves on. Configuration registers are read live by all stages, so
// they must be written only while no transaction is in flight.
module square_path_reference_generator_core #(
  parameter int unsigned POS_WIDTH = sqpg_pkg::PosWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [sqpg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sqpg_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Tick query channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [31:0]                   now_tick_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [POS_WIDTH-1:0]   pos_x_o,
  output logic signed [POS_WIDTH-1:0]   pos_y_o,
  output logic signed [31:0]            vel_x_o,
  output logic signed [31:0]            vel_y_o,
  output logic [15:0]                   heading_o,
  output logic [2:0]                    phase_o
);
  import sqpg_pkg::*;

  localparam int unsigned ProdW = 65;
  localparam int unsigned SumW  = 67;
  localparam logic signed [SumW-1:0] PosHi = (67'sd1 <<< (POS_WIDTH - 1)) - 67'sd1;
  localparam logic signed [SumW-1:0] PosLo = -PosHi - 67'sd1;

  cfg_t cfg;

  sqpg_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Stage valid bits and the stall chain.
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready, out_ready;

  assign out_ready  = !out_valid_q || out_ready_i;
  assign s3_ready   = !s3_valid_q || out_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid_q  <= in_valid_i;
      if (s2_ready)  s2_valid_q  <= s1_valid_q;
      if (s3_ready)  s3_valid_q  <= s2_valid_q;
      if (out_ready) out_valid_q <= s3_valid_q;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 1: elapsed ticks since the start and the velocity scaling products.
  // -------------------------------------------------------------------------
  logic [32:0]        diff_d;
  logic signed [47:0] prod_c_d, prod_s_d;

  logic               s1_before_q;
  logic [31:0]        s1_e_q;
  logic signed [47:0] s1_pc_q, s1_ps_q;

  always_comb begin
    diff_d   = {1'b0, now_tick_i} - {1'b0, cfg.start_time};
    prod_c_d = $signed({1'b0, cfg.speed}) * $signed(cfg.dir_cos);
    prod_s_d = $signed({1'b0, cfg.speed}) * $signed(cfg.dir_sin);
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_before_q <= diff_d[32];
      s1_e_q      <= diff_d[31:0];
      s1_pc_q     <= prod_c_d;
      s1_ps_q     <= prod_s_d;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2: side decode against multiples of the side length, rounding of
  // the first side velocity and the heading.
  // -------------------------------------------------------------------------
  logic [33:0]        t1, t2, t3, t4;
  logic [34:0]        d1, d2, d3, d4;
  logic [2:0]         phase_d;
  logic [31:0]        el_d;
  logic [1:0]         quarters_d;
  logic [15:0]        heading_d;
  logic signed [47:0] rnd_c, rnd_s;

  logic [2:0]         s2_phase_q;
  logic [31:0]        s2_el_q;
  logic signed [31:0] s2_ax_q, s2_ay_q;
  logic [15:0]        s2_heading_q;

  always_comb begin
    t1 = {2'b00, cfg.side_ticks};
    t2 = {1'b0, cfg.side_ticks, 1'b0};
    t4 = {cfg.side_ticks, 2'b00};
    t3 = t1 + t2;
    d1 = {3'b000, s1_e_q} - {1'b0, t1};
    d2 = {3'b000, s1_e_q} - {1'b0, t2};
    d3 = {3'b000, s1_e_q} - {1'b0, t3};
    d4 = {3'b000, s1_e_q} - {1'b0, t4};

    // A side length of zero makes every compare pass, so the path is done.
    el_d = s1_e_q;
    if (s1_before_q) begin
      phase_d = PhBefore;
    end else if (!d4[34]) begin
      phase_d = PhDone;
    end else if (!d3[34]) begin
      phase_d = PhSide4;
      el_d    = d3[31:0];
    end else if (!d2[34]) begin
      phase_d = PhSide3;
      el_d    = d2[31:0];
    end else if (!d1[34]) begin
      phase_d = PhSide2;
      el_d    = d1[31:0];
    end else begin
      phase_d = PhSide1;
    end

    // Heading: quarter turns added to the start heading.
    case (phase_d)
      PhSide2: quarters_d = 2'd1;
      PhSide3: quarters_d = 2'd2;
      PhSide4: quarters_d = 2'd3;
      PhDone:  quarters_d = 2'd3;
      default: quarters_d = 2'd0;
    endcase
    heading_d = (phase_d == PhBefore) ? 16'd0
                                      : cfg.start_heading + {quarters_d, 14'd0};

    // Round half up, then drop the fraction bits of the direction.
    rnd_c = s1_pc_q + 48'sd16384;
    rnd_s = s1_ps_q + 48'sd16384;
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_phase_q   <= phase_d;
      s2_el_q      <= el_d;
      s2_ax_q      <= rnd_c[46:15];
      s2_ay_q      <= rnd_s[46:15];
      s2_heading_q <= heading_d;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 3: pick coefficients and tick counts per side, form the products
  // and the side velocity. The second side velocity is the first turned left.
  // -------------------------------------------------------------------------
  logic [31:0]        rem_d;
  logic signed [31:0] bx, by;
  logic signed [31:0] cx1, cy1, cx2, cy2;
  logic [31:0]        m1, m2;
  logic signed [31:0] vx_d, vy_d;

  logic signed [ProdW-1:0] s3_px1_q, s3_px2_q, s3_py1_q, s3_py2_q;
  logic signed [31:0]      s3_vx_q, s3_vy_q;
  logic [15:0]             s3_heading_q;
  logic [2:0]              s3_phase_q;

  always_comb begin
    rem_d = cfg.side_ticks - s2_el_q;
    bx    = -s2_ay_q;
    by    = s2_ax_q;
    cx1   = '0;
    cy1   = '0;
    cx2   = '0;
    cy2   = '0;
    m1    = '0;
    m2    = '0;
    vx_d  = '0;
    vy_d  = '0;
    case (s2_phase_q)
      PhSide1: begin
        cx1  = s2_ax_q;
        cy1  = s2_ay_q;
        m1   = s2_el_q;
        vx_d = s2_ax_q;
        vy_d = s2_ay_q;
      end
      PhSide2: begin
        cx1  = s2_ax_q;
        cy1  = s2_ay_q;
        m1   = cfg.side_ticks;
        cx2  = bx;
        cy2  = by;
        m2   = s2_el_q;
        vx_d = bx;
        vy_d = by;
      end
      PhSide3: begin
        cx1  = bx;
        cy1  = by;
        m1   = cfg.side_ticks;
        cx2  = s2_ax_q;
        cy2  = s2_ay_q;
        m2   = rem_d;
        vx_d = -s2_ax_q;
        vy_d = -s2_ay_q;
      end
      PhSide4: begin
        cx1  = bx;
        cy1  = by;
        m1   = rem_d;
        vx_d = -bx;
        vy_d = -by;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      s3_px1_q     <= cx1 * $signed({1'b0, m1});
      s3_py1_q     <= cy1 * $signed({1'b0, m1});
      s3_px2_q     <= cx2 * $signed({1'b0, m2});
      s3_py2_q     <= cy2 * $signed({1'b0, m2});
      s3_vx_q      <= vx_d;
      s3_vy_q      <= vy_d;
      s3_heading_q <= s2_heading_q;
      s3_phase_q   <= s2_phase_q;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 4: exact corner plus travel sum, saturated to the position width.
  // -------------------------------------------------------------------------
  logic signed [SumW-1:0] sum_x, sum_y;
  logic [POS_WIDTH-1:0]   pos_x_d, pos_y_d;

  logic signed [POS_WIDTH-1:0] pos_x_q, pos_y_q;
  logic signed [31:0]          vel_x_q, vel_y_q;
  logic [15:0]                 heading_q;
  logic [2:0]                  phase_q;

  always_comb begin
    sum_x = SumW'($signed(cfg.origin_x)) + SumW'(s3_px1_q) + SumW'(s3_px2_q);
    sum_y = SumW'($signed(cfg.origin_y)) + SumW'(s3_py1_q) + SumW'(s3_py2_q);
    if (sum_x > PosHi)      pos_x_d = PosHi[POS_WIDTH-1:0];
    else if (sum_x < PosLo) pos_x_d = PosLo[POS_WIDTH-1:0];
    else                    pos_x_d = sum_x[POS_WIDTH-1:0];
    if (sum_y > PosHi)      pos_y_d = PosHi[POS_WIDTH-1:0];
    else if (sum_y < PosLo) pos_y_d = PosLo[POS_WIDTH-1:0];
    else                    pos_y_d = sum_y[POS_WIDTH-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s3_valid_q) begin
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      vel_x_q   <= s3_vx_q;
      vel_y_q   <= s3_vy_q;
      heading_q <= s3_heading_q;
      phase_q   <= s3_phase_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign vel_x_o     = vel_x_q;
  assign vel_y_o     = vel_y_q;
  assign heading_o   = heading_q;
  assign phase_o     = phase_q;

endmodule

[src/sqpg_checker.sv]
// ---------------------------------------------------------------------------
// sqpg_checker
// Port-level checks of the square path reference generator, attached to the
// top level by a bind statement.
// ---------------------------------------------------------------------------
module sqpg_checker #(
  parameter int unsigned POS_WIDTH = sqpg_pkg::PosWidthDef
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic signed [POS_WIDTH-1:0] pos_x_o,
  input logic signed [31:0]          vel_x_o,
  input logic signed [31:0]          vel_y_o,
  input logic [15:0]                 heading_o,
  input logic [2:0]                  phase_o
);
  import sqpg_pkg::*;

  // A stalled result stays offered with its position unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o))
    else $error("stalled result dropped or changed");

  // Only defined phase codes are ever delivered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (phase_o <= PhDone))
    else $error("undefined phase code delivered");

  // Before the start the robot stands at heading zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (phase_o == PhBefore) |-> (heading_o == 16'd0) &&
      (vel_x_o == 32'sd0) && (vel_y_o == 32'sd0))
    else $error("non-zero heading or velocity before the start");

  // After the last side the robot stands still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (phase_o == PhDone) |-> (vel_x_o == 32'sd0) && (vel_y_o == 32'sd0))
    else $error("non-zero velocity after the path is done");

endmodule

bind square_path_reference_generator_core sqpg_checker #(
  .POS_WIDTH (POS_WIDTH)
) u_sqpg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .pos_x_o     (pos_x_o),
  .vel_x_o     (vel_x_o),
  .vel_y_o     (vel_y_o),
  .heading_o   (heading_o),
  .phase_o     (phase_o)
);
